@@ hw/rtl/cbqt_pkg.sv @@
// types, constants and register codes shared by the bandwidth quota throttle
`timescale 1ns / 1ps

package cbqt_pkg;

  localparam int unsigned TimeW  = 64;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TimeW-1:0] PeriodResetNs = 64'd100000000;

  // register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] CfgQuotaEnabled = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgQuotaNs      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPeriodNs     = 2'd2;

  typedef enum logic {
    CMD_ACCOUNT = 1'b0,
    CMD_CHECK   = 1'b1
  } cmd_e;

  typedef struct packed {
    logic             quota_enabled;
    logic [TimeW-1:0] quota_ns;
    logic [TimeW-1:0] period_ns;
  } cfg_t;

  typedef struct packed {
    cmd_e             cmd;
    logic [TimeW-1:0] delta_ns;
    logic [TimeW-1:0] now_ns;
  } item_t;

  typedef struct packed {
    logic [TimeW-1:0]  period_used;
    logic [TimeW-1:0]  window_start;
    logic              throttle_flag;
    logic [CountW-1:0] event_count;
    logic [TimeW-1:0]  stalled_time;
    logic [TimeW-1:0]  lifetime_runtime;
  } state_t;

  typedef struct packed {
    logic              throttle_now;
    logic              released;
    logic              is_throttled;
    logic [CountW-1:0] throttle_events;
    logic [TimeW-1:0]  throttled_total_ns;
    logic [TimeW-1:0]  runtime_total_ns;
    logic [TimeW-1:0]  period_runtime_ns;
  } result_t;

endpackage

@@ hw/rtl/cbqt_core.sv @@
// next-state and result logic for one account or check transaction
`timescale 1ns / 1ps

module cbqt_core (
  input  cbqt_pkg::state_t  state_i,
  input  cbqt_pkg::cfg_t    cfg_i,
  input  cbqt_pkg::item_t   item_i,
  output cbqt_pkg::state_t  state_o,
  output cbqt_pkg::result_t res_o
);

  logic                          is_account;
  logic [cbqt_pkg::TimeW-1:0]    start_eff;
  logic [cbqt_pkg::TimeW-1:0]    since_start;
  logic                          over;
  logic [cbqt_pkg::TimeW-1:0]    stall_add;
  logic [cbqt_pkg::TimeW-1:0]    used_base;
  logic [cbqt_pkg::TimeW-1:0]    used_new;
  logic                          hit;
  logic                          rel;
  cbqt_pkg::state_t              nxt;

  assign is_account = (item_i.cmd == cbqt_pkg::CMD_ACCOUNT);

  // an account transaction starts the window at now when it was never started
  assign start_eff   = (is_account && (state_i.window_start == '0)) ?
                       item_i.now_ns : state_i.window_start;
  assign since_start = item_i.now_ns - start_eff;
  assign over        = (since_start >= cfg_i.period_ns);
  assign stall_add   = since_start - state_i.period_used;
  assign used_base   = over ? '0 : state_i.period_used;
  assign used_new    = used_base + item_i.delta_ns;

  always_comb begin
    nxt = state_i;
    hit = 1'b0;
    rel = 1'b0;
    if (is_account) begin
      if (cfg_i.quota_enabled) begin
        nxt.window_start = start_eff;
        if (over) begin
          if (state_i.throttle_flag) begin
            nxt.stalled_time = state_i.stalled_time + stall_add;
          end
          nxt.window_start  = item_i.now_ns;
          nxt.throttle_flag = 1'b0;
        end
        nxt.period_used      = used_new;
        nxt.lifetime_runtime = state_i.lifetime_runtime + item_i.delta_ns;
        if (used_new >= cfg_i.quota_ns) begin
          nxt.throttle_flag = 1'b1;
          hit               = 1'b1;
          if (state_i.event_count != '1) begin
            nxt.event_count = state_i.event_count + 1'b1;
          end
        end
      end
    end else begin
      if (state_i.throttle_flag && over) begin
        nxt.stalled_time  = state_i.stalled_time + stall_add;
        nxt.period_used   = '0;
        nxt.window_start  = item_i.now_ns;
        nxt.throttle_flag = 1'b0;
        rel               = 1'b1;
      end
    end
  end

  assign state_o = nxt;

  always_comb begin
    res_o.throttle_now       = hit;
    res_o.released           = rel;
    res_o.is_throttled       = nxt.throttle_flag;
    res_o.throttle_events    = nxt.event_count;
    res_o.throttled_total_ns = nxt.stalled_time;
    res_o.runtime_total_ns   = nxt.lifetime_runtime;
    res_o.period_runtime_ns  = nxt.period_used;
  end

endmodule

@@ hw/rtl/cpu_bandwidth_quota_throttle_top.sv @@
// top level of the per-group cpu bandwidth quota throttle
`timescale 1ns / 1ps

// Per-group cpu bandwidth limiter. Each input transaction (tuser = cmd) either
// accounts elapsed run time against the period quota or checks whether a
// throttled group may be released; each one yields exactly one result
// transaction with the flags and counters after it. One transaction is taken
// every clock cycle unless back-pressure stalls the output; the input register
// and the result register lie around the single-pass update of the group state.
// The user must write configuration via the cfg channel while no transaction
// is in flight; the block does not enforce it. No clearing pass follows reset.

module cpu_bandwidth_quota_throttle_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cbqt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cbqt_pkg::TimeW-1:0]     cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // delta_ns [63:0], now_ns [127:64]
  input  logic [127:0]                   s_axis_tdata,
  // cmd [0]
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // throttle_now [0], released [1], is_throttled [2], throttle_events [34:3],
  // throttled_total_ns [98:35], runtime_total_ns [162:99],
  // period_runtime_ns [226:163], zero [231:227]
  output logic [231:0]                   m_axis_tdata
);

  cbqt_pkg::cfg_t    cfg_q;
  cbqt_pkg::state_t  st_q;
  cbqt_pkg::state_t  st_d;
  cbqt_pkg::item_t   in_q;
  cbqt_pkg::result_t res_q;
  cbqt_pkg::result_t res_d;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              advance;
  logic              in_take;

  assign cfg_ready_o   = 1'b1;
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quota_enabled <= 1'b0;
      cfg_q.quota_ns      <= '0;
      cfg_q.period_ns     <= cbqt_pkg::PeriodResetNs;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cbqt_pkg::CfgQuotaEnabled: cfg_q.quota_enabled <= cfg_data_i[0];
        cbqt_pkg::CfgQuotaNs:      cfg_q.quota_ns      <= cfg_data_i;
        cbqt_pkg::CfgPeriodNs:     cfg_q.period_ns     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.cmd      <= cbqt_pkg::cmd_e'(s_axis_tuser[0]);
      in_q.delta_ns <= s_axis_tdata[63:0];
      in_q.now_ns   <= s_axis_tdata[127:64];
    end
  end

  cbqt_core u_core (
    .state_i (st_q),
    .cfg_i   (cfg_q),
    .item_i  (in_q),
    .state_o (st_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0,
                          res_q.period_runtime_ns,
                          res_q.runtime_total_ns,
                          res_q.throttled_total_ns,
                          res_q.throttle_events,
                          res_q.is_throttled,
                          res_q.released,
                          res_q.throttle_now};

`ifndef SYNTHESIS
  a_hit_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.throttle_now) |-> res_q.is_throttled)
    else $error("throttle_now without throttle flag");

  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.released) |->
      (!res_q.is_throttled && (res_q.period_runtime_ns == '0)))
    else $error("release left throttle or period run time");

  a_hit_rel_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(res_q.throttle_now && res_q.released))
    else $error("throttle and release in one result");

  a_events_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (st_q.event_count >= $past(st_q.event_count)))
    else $error("throttle event count went down");

  a_state_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && in_valid_q) |=> $stable(st_q))
    else $error("group state changed without a transaction");
`endif

endmodule

@@ sim/tb_cpu_bandwidth_quota_throttle_top.sv @@
// self-checking testbench for the cpu bandwidth quota throttle top level
`timescale 1ns / 1ps

module tb_cpu_bandwidth_quota_throttle_top;
  import cbqt_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnmapped = 2'd3;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned QuietLimit = 2000;
  localparam logic [TimeW-1:0] TimeMax = '1;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [TimeW-1:0]    cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [127:0]        s_axis_tdata = '0;
  logic [0:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [231:0]        m_axis_tdata;

  cpu_bandwidth_quota_throttle_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // group state as the block should hold it
  logic              set_enabled = 1'b0;
  logic [TimeW-1:0]  set_quota = '0;
  logic [TimeW-1:0]  set_period = PeriodResetNs;
  logic [TimeW-1:0]  grp_used = '0;
  logic [TimeW-1:0]  grp_start = '0;
  logic              grp_throttled = 1'b0;
  logic [CountW-1:0] grp_events = '0;
  logic [TimeW-1:0]  grp_stalled = '0;
  logic [TimeW-1:0]  grp_lifetime = '0;

  result_t expected_results[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned throttle_hits = 0;
  int unsigned releases_seen = 0;
  int unsigned quiet_cycles = 0;

  int unsigned burst_left = 0;
  bit          tx_gaps = 1'b1;
  bit          hold_req = 1'b0;

  task automatic predict_group_step(cmd_e cmd, logic [TimeW-1:0] elapsed,
                                    logic [TimeW-1:0] now);
    result_t r;
    r = '0;
    if (cmd == CMD_ACCOUNT) begin
      if (set_enabled) begin
        if (grp_start == '0) grp_start = now;
        if (now - grp_start >= set_period) begin
          if (grp_throttled) grp_stalled = grp_stalled + ((now - grp_start) - grp_used);
          grp_used = '0;
          grp_start = now;
          grp_throttled = 1'b0;
        end
        grp_used = grp_used + elapsed;
        grp_lifetime = grp_lifetime + elapsed;
        if (grp_used >= set_quota) begin
          grp_throttled = 1'b1;
          if (grp_events != '1) grp_events = grp_events + 1'b1;
          r.throttle_now = 1'b1;
          throttle_hits++;
        end
      end
    end else if (grp_throttled && (now - grp_start >= set_period)) begin
      // release always books the throttled stretch, even with quota disabled
      grp_stalled = grp_stalled + ((now - grp_start) - grp_used);
      grp_used = '0;
      grp_start = now;
      grp_throttled = 1'b0;
      r.released = 1'b1;
      releases_seen++;
    end
    r.is_throttled       = grp_throttled;
    r.throttle_events    = grp_events;
    r.throttled_total_ns = grp_stalled;
    r.runtime_total_ns   = grp_lifetime;
    r.period_runtime_ns  = grp_used;
    expected_results.push_back(r);
  endtask

  task automatic send_item(cmd_e cmd, logic [TimeW-1:0] elapsed, logic [TimeW-1:0] now);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (tx_gaps) gap = $urandom_range(1, 5);
    end
    burst_left--;
    if (gap != 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {now, elapsed};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    predict_group_step(cmd, elapsed, now);
  endtask

  task automatic write_cfg_reg(logic [CfgIdxW-1:0] idx, logic [TimeW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
    case (idx)
      CfgQuotaEnabled: set_enabled = data[0];
      CfgQuotaNs:      set_quota = data;
      CfgPeriodNs:     set_period = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_pipeline();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_unlimited_quota();
    // reset state: quota disabled, accounting must be a no-op
    send_item(CMD_ACCOUNT, TimeMax, TimeMax);
    send_item(CMD_CHECK, TimeMax, '0);
  endtask

  task automatic test_throttle_and_release();
    drain_pipeline();
    write_cfg_reg(CfgQuotaEnabled, 64'd1);
    write_cfg_reg(CfgQuotaNs, 64'd1000);
    write_cfg_reg(CfgPeriodNs, 64'd10000);
    send_item(CMD_ACCOUNT, 64'd0, 64'd0);       // window start at zero stays unstarted
    send_item(CMD_ACCOUNT, 64'd400, 64'd50);
    send_item(CMD_ACCOUNT, 64'd600, 64'd60);    // reaches quota exactly
    send_item(CMD_CHECK, 64'd0, 64'd100);       // period not over yet
    send_item(CMD_CHECK, 64'd0, 64'd10050);     // release
    send_item(CMD_ACCOUNT, 64'd2000, 64'd10060);
    send_item(CMD_ACCOUNT, 64'd5, 64'd30000);   // period ends while throttled
    send_item(CMD_CHECK, 64'd0, 64'd30001);     // not throttled: nothing happens
    drain_pipeline();
  endtask

  task automatic test_wrap_and_backwards_time();
    send_item(CMD_ACCOUNT, TimeMax, 64'd30001);  // run time sums wrap
    send_item(CMD_ACCOUNT, 64'd1000, 64'd5);     // clock went backwards
    send_item(CMD_CHECK, 64'd0, 64'd0);          // backwards again, stall diff wraps
    drain_pipeline();
  endtask

  task automatic test_register_extremes();
    write_cfg_reg(CfgQuotaNs, 64'd0);
    write_cfg_reg(CfgPeriodNs, 64'd0);
    send_item(CMD_ACCOUNT, 64'd0, 64'd123);
    send_item(CMD_ACCOUNT, 64'd0, 64'd123);
    send_item(CMD_CHECK, 64'd0, 64'd123);
    drain_pipeline();
    write_cfg_reg(CfgQuotaNs, TimeMax);
    write_cfg_reg(CfgPeriodNs, TimeMax);
    write_cfg_reg(CfgUnmapped, 64'h5555_aaaa_5555_aaaa);  // unmapped index is dropped
    send_item(CMD_ACCOUNT, TimeMax - 1, 64'd1);
    send_item(CMD_ACCOUNT, 64'd1, 64'd2);
    drain_pipeline();
    // a throttled group is released even with the quota turned off
    write_cfg_reg(CfgQuotaEnabled, 64'hffff_ffff_ffff_fffe);
    write_cfg_reg(CfgPeriodNs, 64'd0);
    send_item(CMD_ACCOUNT, 64'd7, 64'd9);
    send_item(CMD_CHECK, 64'd0, TimeMax);
    send_item(CMD_CHECK, 64'd0, TimeMax);
    drain_pipeline();
  endtask

  task automatic test_output_backpressure();
    logic [TimeW-1:0] clock_ns;
    write_cfg_reg(CfgQuotaEnabled, 64'd1);
    write_cfg_reg(CfgQuotaNs, 64'd500);
    write_cfg_reg(CfgPeriodNs, 64'd2000);
    clock_ns = 64'd1000;
    tx_gaps = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 48; i++) begin
      clock_ns = clock_ns + $urandom_range(0, 700);
      if ($urandom_range(0, 3) == 0) send_item(CMD_CHECK, {$urandom, $urandom}, clock_ns);
      else send_item(CMD_ACCOUNT, $urandom_range(0, 300), clock_ns);
    end
    drain_pipeline();
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_phase(int unsigned n_items);
    logic [TimeW-1:0] period_v;
    logic [TimeW-1:0] quota_v;
    logic [TimeW-1:0] clock_ns;
    logic [TimeW-1:0] enable_v;
    int unsigned step_span;
    int unsigned elapsed_span;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: period_v = '0;
      1: period_v = TimeMax;
      2: period_v = PeriodResetNs;
      default: period_v = $urandom_range(20, 5000);
    endcase
    pick = $urandom_range(0, 9);
    case (pick)
      0: quota_v = '0;
      1: quota_v = TimeMax;
      default: quota_v = (period_v > 64'd5000 ? 64'd5000 : period_v)
                         * $urandom_range(1, 9) / 10 + 1;
    endcase
    enable_v = {$urandom, $urandom};
    enable_v[0] = ($urandom_range(0, 5) != 0);
    write_cfg_reg(CfgQuotaEnabled, enable_v);
    write_cfg_reg(CfgQuotaNs, quota_v);
    write_cfg_reg(CfgPeriodNs, period_v);

    if (period_v != '0 && period_v < 64'd3_000_000_000) step_span = period_v / 3 + 1;
    else step_span = 2000;
    if (quota_v < 64'd2_000_000_000) elapsed_span = quota_v / 2 + 1;
    else elapsed_span = 100000;

    pick = $urandom_range(0, 3);
    case (pick)
      0: clock_ns = '0;
      1: clock_ns = 64'hffff_ffff_ffff_0000;  // let the clock wrap mid phase
      default: clock_ns = {32'h0, $urandom};
    endcase
    tx_gaps = ($urandom_range(0, 3) != 0);

    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_item(cmd_e'($urandom_range(0, 1)), {$urandom, $urandom}, {$urandom, $urandom});
      end else begin
        clock_ns = clock_ns + $urandom_range(0, step_span);
        if (pick < 36) send_item(CMD_CHECK, {$urandom, $urandom}, clock_ns);
        else send_item(CMD_ACCOUNT, $urandom_range(0, elapsed_span), clock_ns);
      end
    end
    drain_pipeline();
  endtask

  // result receiver: random ready pattern plus one long hold-off on request
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_stall_left = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_tick = 0;

  initial begin
    forever begin
      @(negedge clk_i);
      rx_tick++;
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        rx_hold_left = HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(0, 1);
          2: m_axis_tready <= (rx_tick % 3 != 0);
          default: begin
            if (rx_stall_left != 0) begin
              rx_stall_left--;
              m_axis_tready <= 1'b0;
            end else begin
              m_axis_tready <= 1'b1;
              if ($urandom_range(0, 9) == 0) rx_stall_left = $urandom_range(1, 12);
            end
          end
        endcase
      end
    end
  end

  function automatic void check_field(string name, logic [TimeW-1:0] want_v,
                                      logic [TimeW-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result transaction with none expected, actual %0h", $time,
                 m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("throttle_now", want.throttle_now, m_axis_tdata[0]);
        check_field("released", want.released, m_axis_tdata[1]);
        check_field("is_throttled", want.is_throttled, m_axis_tdata[2]);
        check_field("throttle_events", want.throttle_events, m_axis_tdata[34:3]);
        check_field("throttled_total_ns", want.throttled_total_ns, m_axis_tdata[98:35]);
        check_field("runtime_total_ns", want.runtime_total_ns, m_axis_tdata[162:99]);
        check_field("period_runtime_ns", want.period_runtime_ns, m_axis_tdata[226:163]);
        check_field("pad", '0, m_axis_tdata[231:227]);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
                 quiet_cycles, expected_results.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_unlimited_quota();
    test_throttle_and_release();
    test_wrap_and_backwards_time();
    test_register_extremes();
    test_output_backpressure();
    repeat (5) test_random_phase(190);

    drain_pipeline();
    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      mismatches++;
    end
    $display("tb: %0d items and %0d register writes, %0d throttles and %0d releases",
             items_sent, reg_writes, throttle_hits, releases_seen);
    $display("tb: settings included zero and full-scale quota and period, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/cbqt_pkg.sv
hw/rtl/cbqt_core.sv
hw/rtl/cpu_bandwidth_quota_throttle_top.sv
sim/tb_cpu_bandwidth_quota_throttle_top.sv
